[rtl/core/lcs_pkg.sv]
// Shared constants, types and helpers for the longest common substring block.
package lcs_pkg;

	// Number of reference cells in the chain.
	localparam int MAX_LEN = 256;
	// Width of a run length; a run can reach MAX_LEN.
	localparam int RUN_W = $clog2(MAX_LEN + 1);

	localparam int MODE_W = 2;
	localparam int SYM_W = 8;
	localparam int LONGEST_W = 9;

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

	typedef logic [RUN_W-1:0] run_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic              append;
		logic              query;
		logic              clear;
		logic [SYM_W-1:0]  symbol;
	} cell_ctl_t;

	// Status from the end of the chain back to the controller.
	typedef struct packed {
		logic full;
		run_t best;
	} row_stat_t;

	typedef enum logic {
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Clamps a run length to the width of the result field.
	function automatic logic [LONGEST_W-1:0] sat_longest(input run_t v);
		logic [RUN_W+LONGEST_W-1:0] wide;
		wide = {{LONGEST_W{1'b0}}, v};
		if (wide > {{RUN_W{1'b0}}, {LONGEST_W{1'b1}}}) begin
			return {LONGEST_W{1'b1}};
		end
		return wide[LONGEST_W-1:0];
	endfunction

endpackage

[rtl/core/lcs_cell.sv]
// One cell of the chain: a stored reference byte, its run length and a local maximum.
module lcs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lcs_pkg::cell_ctl_t ctl,
	input  logic               left_valid,
	input  lcs_pkg::run_t      left_run,
	input  lcs_pkg::run_t      left_max,
	output logic               valid,
	output lcs_pkg::run_t      run,
	output lcs_pkg::run_t      max_out
);

	logic [lcs_pkg::SYM_W-1:0] ch_q;
	logic                      valid_q;
	lcs_pkg::run_t             run_q;
	lcs_pkg::run_t             best_q;
	lcs_pkg::run_t             max_q;
	lcs_pkg::run_t             run_d;
	logic                      match;

	assign match = valid_q && (ctl.symbol == ch_q);
	assign run_d = match ? lcs_pkg::run_t'(left_run + 1'b1) : '0;

	// The first empty cell behind a filled neighbor takes the next reference byte.
	always_ff @(posedge clk) begin
		if (ctl.append && left_valid && !valid_q) begin
			ch_q <= ctl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			run_q   <= '0;
			best_q  <= '0;
			max_q   <= '0;
		end else begin
			if (ctl.clear) begin
				valid_q <= 1'b0;
				run_q   <= '0;
				best_q  <= '0;
			end else if (ctl.append && left_valid && !valid_q) begin
				valid_q <= 1'b1;
				run_q   <= '0;
			end else if (ctl.query) begin
				run_q <= run_d;
				if (run_d > best_q) begin
					best_q <= run_d;
				end
			end
			// The running maximum ripples one cell further each cycle.
			max_q <= (left_max > best_q) ? left_max : best_q;
		end
	end

	assign valid   = valid_q;
	assign run     = run_q;
	assign max_out = max_q;

endmodule

[rtl/core/lcs_row.sv]
// The chain of cells, each linked to its left neighbor.
module lcs_row (
	input  logic               clk,
	input  logic               arst_n,
	input  lcs_pkg::cell_ctl_t ctl,
	output lcs_pkg::row_stat_t stat
);

	logic          valid [lcs_pkg::MAX_LEN];
	lcs_pkg::run_t run   [lcs_pkg::MAX_LEN];
	lcs_pkg::run_t mx    [lcs_pkg::MAX_LEN];

	for (genvar j = 0; j < lcs_pkg::MAX_LEN; j++) begin : g_cell
		if (j == 0) begin : g_first
			lcs_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.left_valid (1'b1),
				.left_run   ('0),
				.left_max   ('0),
				.valid      (valid[j]),
				.run        (run[j]),
				.max_out    (mx[j])
			);
		end else begin : g_next
			lcs_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.left_valid (valid[j-1]),
				.left_run   (run[j-1]),
				.left_max   (mx[j-1]),
				.valid      (valid[j]),
				.run        (run[j]),
				.max_out    (mx[j])
			);
		end
	end

	assign stat.full = valid[lcs_pkg::MAX_LEN-1];
	assign stat.best = mx[lcs_pkg::MAX_LEN-1];

endmodule

[rtl/core/longest_common_substring_length.sv]
// Top level: stream control, result register and the chain of reference cells.
// Reference bytes (mode 0) and query bytes (mode 1) are taken one beat per cycle while
// no drain runs, and an unused mode code is taken and ignored. Each query byte updates
// every stored cell in the same cycle. A finish beat (mode 2) starts a drain while the
// running maximum travels one cell per cycle down the chain; the drain lasts longer
// while an earlier result still waits at the output. Input is held off during the drain,
// then the block is cleared and ready again. Reference bytes beyond MAX_LEN are dropped
// and reported in the result.
// No clearing pass is needed after reset.
module longest_common_substring_length (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] symbol
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [8:0] longest, [9] ref_overflow, [15:10] zero
);

	lcs_pkg::state_t    state_q, state_d;
	lcs_pkg::run_t      cnt_q;
	logic               dropped_q;
	logic               m_tvalid_q;
	logic [lcs_pkg::LONGEST_W-1:0] longest_q;
	logic               overflow_q;
	logic               s_acc;
	logic               drain_end;
	logic               drain_done;
	lcs_pkg::cell_ctl_t ctl;
	lcs_pkg::row_stat_t stat;

	assign s_acc     = s_tvalid && s_tready;
	assign drain_end = (cnt_q == lcs_pkg::run_t'(lcs_pkg::MAX_LEN));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcs_pkg::ST_RUN: begin
				if (s_acc && (s_tuser == lcs_pkg::MODE_FINISH)) begin
					state_d = lcs_pkg::ST_DRAIN;
				end
			end
			lcs_pkg::ST_DRAIN: begin
				if (drain_done) begin
					state_d = lcs_pkg::ST_RUN;
				end
			end
			default: state_d = lcs_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		drain_done = 1'b0;
		unique case (state_q)
			lcs_pkg::ST_RUN:   s_tready = 1'b1;
			lcs_pkg::ST_DRAIN: drain_done = drain_end && (!m_tvalid_q || m_tready);
			default: begin
				s_tready   = 1'b0;
				drain_done = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctl.append = 1'b0;
		ctl.query  = 1'b0;
		ctl.clear  = drain_done;
		ctl.symbol = s_tdata;
		if (s_acc) begin
			unique case (s_tuser)
				lcs_pkg::MODE_APPEND: ctl.append = 1'b1;
				lcs_pkg::MODE_QUERY:  ctl.query  = 1'b1;
				default: begin
					ctl.append = 1'b0;
					ctl.query  = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lcs_pkg::ST_RUN;
			cnt_q      <= '0;
			dropped_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lcs_pkg::ST_DRAIN && !drain_end) begin
				cnt_q <= lcs_pkg::run_t'(cnt_q + 1'b1);
			end else if (drain_done) begin
				cnt_q <= '0;
			end
			if (drain_done) begin
				dropped_q <= 1'b0;
			end else if (ctl.append && stat.full) begin
				dropped_q <= 1'b1;
			end
			if (drain_done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_done) begin
			longest_q  <= lcs_pkg::sat_longest(stat.best);
			overflow_q <= dropped_q;
		end
	end

	lcs_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, overflow_q, longest_q};

endmodule

[rtl/core/lcs_checker.sv]
// Port-level checks for the longest common substring block, bound to the top level.
module lcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A finish beat holds off input while the maximum is gathered.
	a_finish_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == lcs_pkg::MODE_FINISH) |=> !s_tready)
		else $error("input still ready after a finish beat");

	// Other beats never stall the input.
	a_other_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser != lcs_pkg::MODE_FINISH) |=> s_tready)
		else $error("input stalled after a non-finish beat");

	// A new result only appears at the end of a drain.
	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a drain");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind longest_common_substring_length lcs_checker u_lcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/lcs_length_checker.sv]
// Watches both streams of the substring block, predicts each report and compares it.
`timescale 1ns / 1ps

module lcs_length_checker
	import lcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] symbol
	input  logic [1:0]  s_tuser,  // [1:0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // [8:0] longest, [9] ref_overflow, [15:10] zero
	output int          fail_count,
	output int          reports_due
);

	localparam int LONGEST_CAP = (1 << LONGEST_W) - 1;

	typedef struct packed {
		logic [LONGEST_W-1:0] longest;
		logic                 overflow;
	} report_t;

	logic [SYM_W-1:0] ref_chars [MAX_LEN];
	run_t             run_len [MAX_LEN];
	int               ref_len;
	run_t             best;
	logic             dropped;
	report_t          due_q [$];
	int               errs = 0;

	function automatic void clear_model();
		ref_len = 0;
		best = '0;
		dropped = 1'b0;
		foreach (run_len[k]) begin
			run_len[k] = '0;
		end
	endfunction

	function automatic void store_ref_char(input logic [SYM_W-1:0] sym);
		if (ref_len < MAX_LEN) begin
			ref_chars[ref_len] = sym;
			run_len[ref_len] = '0;
			ref_len++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	// Walk the row from the top so every cell still sees its left neighbor's old run.
	function automatic void advance_runs(input logic [SYM_W-1:0] sym);
		run_t v;
		for (int k = ref_len - 1; k >= 0; k--) begin
			if (ref_chars[k] == sym) begin
				v = (k > 0) ? run_len[k-1] + run_t'(1) : run_t'(1);
				run_len[k] = v;
				if (v > best) begin
					best = v;
				end
			end else begin
				run_len[k] = '0;
			end
		end
	endfunction

	function automatic report_t finish_report();
		report_t r;
		r.longest = (int'(best) > LONGEST_CAP) ? {LONGEST_W{1'b1}} : LONGEST_W'(best);
		r.overflow = dropped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		report_t got;
		report_t want;
		if (!arst_n) begin
			clear_model();
			due_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					MODE_APPEND: store_ref_char(s_tdata);
					MODE_QUERY: advance_runs(s_tdata);
					MODE_FINISH: begin
						due_q.push_back(finish_report());
						clear_model();
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.longest = m_tdata[LONGEST_W-1:0];
				got.overflow = m_tdata[LONGEST_W];
				if (due_q.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("unexpected report beat: longest %0d ref_overflow %0b",
							got.longest, got.overflow);
					end
				end else begin
					want = due_q.pop_front();
					if (got.longest !== want.longest || got.overflow !== want.overflow) begin
						errs++;
						if (errs <= 10) begin
							$display({"report mismatch: longest exp %0d got %0d, ",
								"ref_overflow exp %0b got %0b"},
								want.longest, got.longest, want.overflow, got.overflow);
						end
					end
				end
			end
		end
		reports_due <= due_q.size();
		fail_count <= errs;
	end

endmodule

[tb/sv/tb_longest_common_substring_length.sv]
// Stimulus and verdict for the longest common substring length block.
`timescale 1ns / 1ps

module tb_longest_common_substring_length;
	import lcs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1550;

	localparam int SEQ_NORMAL   = 0;
	localparam int SEQ_FULL_RUN = 1;
	localparam int SEQ_OVERFLOW = 2;
	localparam int SEQ_BROKEN   = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int fail_count;
	int reports_due;
	int items_sent = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit rx_armed = 1'b0;
	int rx_hold = 0;

	logic [SYM_W-1:0] alphabet [4];
	int               alphabet_n = 1;

	always #1 clk = ~clk;

	longest_common_substring_length u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lcs_length_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.reports_due (reports_due)
	);

	// Once a report beat shows up, keep it waiting for a drawn number of cycles.
	always @(posedge clk) begin : rx_pace
		logic nxt;
		nxt = m_tready;
		if (m_tvalid && m_tready) begin
			rx_armed = 1'b0;
			nxt = rx_quiet || ($urandom_range(0, 1) == 1);
		end else if (m_tvalid && !rx_armed) begin
			rx_armed = 1'b1;
			rx_hold = rx_quiet ? 0 : $urandom_range(0, 7);
			nxt = (rx_hold == 0);
		end else if (m_tvalid) begin
			if (rx_hold > 0) begin
				rx_hold--;
			end
			nxt = (rx_hold == 0);
		end
		m_tready <= nxt;
	end

	task automatic send_beat(input logic [1:0] mode, input logic [7:0] sym);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= sym;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (mode != MODE_UNUSED) begin
			items_sent++;
		end
	endtask

	// Now and then an unused mode code slips in ahead of a real beat.
	task automatic send_char(input logic [1:0] mode, input logic [7:0] sym);
		if ($urandom_range(0, 19) == 0) begin
			send_beat(MODE_UNUSED, 8'($urandom_range(0, 255)));
		end
		send_beat(mode, sym);
	endtask

	function automatic logic [7:0] draw_symbol();
		if ($urandom_range(0, 9) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return alphabet[$urandom_range(0, alphabet_n - 1)];
	endfunction

	task automatic play_string_pair(input int kind);
		logic [7:0] ref_seen [$];
		logic [7:0] c;
		int ref_n;
		int qry_n;
		int i;
		int j;
		int span;
		tx_quiet = ($urandom_range(0, 3) == 0);
		rx_quiet = ($urandom_range(0, 3) == 0);
		alphabet_n = $urandom_range(1, 4);
		foreach (alphabet[k]) begin
			alphabet[k] = 8'($urandom_range(0, 255));
		end
		case (kind)
			SEQ_FULL_RUN: begin
				// One symbol everywhere drives the run up to the full store length.
				ref_n = MAX_LEN + $urandom_range(0, 3);
				repeat (ref_n) send_beat(MODE_APPEND, alphabet[0]);
				qry_n = MAX_LEN + $urandom_range(0, 4);
				repeat (qry_n) send_beat(MODE_QUERY, alphabet[0]);
			end
			SEQ_BROKEN: begin
				qry_n = $urandom_range(1, 20);
				repeat (qry_n) begin
					case ($urandom_range(0, 2))
						0: send_beat(MODE_APPEND, draw_symbol());
						1: send_beat(MODE_QUERY, draw_symbol());
						default: send_beat(MODE_UNUSED, draw_symbol());
					endcase
				end
			end
			default: begin
				ref_n = (kind == SEQ_OVERFLOW) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 6)
					: $urandom_range(0, 16);
				for (i = 0; i < ref_n; i++) begin
					c = draw_symbol();
					ref_seen.push_back(c);
					send_char(MODE_APPEND, c);
				end
				qry_n = (kind == SEQ_OVERFLOW) ? $urandom_range(0, 24) : $urandom_range(0, 16);
				i = 0;
				while (i < qry_n) begin
					if ($urandom_range(0, 15) == 0) begin
						c = draw_symbol();
						ref_seen.push_back(c);
						send_char(MODE_APPEND, c);
					end else if (ref_seen.size() > 0 && $urandom_range(0, 1) == 1) begin
						// Copy a slice of the reference, with the odd corrupted byte.
						j = $urandom_range(0, ref_seen.size() - 1);
						span = $urandom_range(1, 8);
						while (span > 0 && j < ref_seen.size() && i < qry_n) begin
							c = ($urandom_range(0, 15) == 0) ? draw_symbol() : ref_seen[j];
							send_char(MODE_QUERY, c);
							j++;
							span--;
							i++;
						end
					end else begin
						send_char(MODE_QUERY, draw_symbol());
						i++;
					end
				end
			end
		endcase
		send_beat(MODE_FINISH, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		#2000000;
		$display("tb_longest_common_substring_length: FAIL");
		$finish;
	end

	initial begin : stimulus
		int seq;
		int kind;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both strings empty.
		send_beat(MODE_FINISH, 8'h00);
		// Extreme bytes, zero byte included, matching in order.
		send_beat(MODE_APPEND, 8'h00);
		send_beat(MODE_APPEND, 8'hFF);
		send_beat(MODE_QUERY, 8'h00);
		send_beat(MODE_QUERY, 8'hFF);
		send_beat(MODE_FINISH, 8'hFF);
		// Empty query string.
		send_beat(MODE_APPEND, 8'hA5);
		send_beat(MODE_APPEND, 8'h5A);
		send_beat(MODE_FINISH, 8'h5A);
		// Empty reference string.
		send_beat(MODE_QUERY, 8'h12);
		send_beat(MODE_QUERY, 8'h12);
		send_beat(MODE_FINISH, 8'hA5);
		// Unused mode and reference characters added after queries.
		send_beat(MODE_UNUSED, 8'hFF);
		send_beat(MODE_APPEND, 8'h3C);
		send_beat(MODE_QUERY, 8'h3C);
		send_beat(MODE_APPEND, 8'h3C);
		send_beat(MODE_UNUSED, 8'h00);
		send_beat(MODE_QUERY, 8'h3C);
		send_beat(MODE_QUERY, 8'h3C);
		send_beat(MODE_FINISH, 8'hC3);

		seq = 0;
		while (items_sent < ITEM_TARGET) begin
			if (seq == 0) begin
				kind = SEQ_FULL_RUN;
			end else if (seq % 10 == 4) begin
				kind = SEQ_OVERFLOW;
			end else if ($urandom_range(0, 7) == 0) begin
				kind = SEQ_BROKEN;
			end else begin
				kind = SEQ_NORMAL;
			end
			play_string_pair(kind);
			seq++;
		end
		s_tvalid <= 1'b0;

		// Let the checker count the last finish beat before waiting on it.
		@(posedge clk);
		while (reports_due != 0) begin
			@(posedge clk);
		end
		repeat (MAX_LEN + 20) @(posedge clk);
		if (fail_count == 0 && reports_due == 0) begin
			$display("tb_longest_common_substring_length: PASS");
		end else begin
			$display("tb_longest_common_substring_length: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/lcs_pkg.sv
rtl/core/lcs_cell.sv
rtl/core/lcs_row.sv
rtl/core/longest_common_substring_length.sv
rtl/core/lcs_checker.sv
tb/sv/lcs_length_checker.sv
tb/sv/tb_longest_common_substring_length.sv
